@@ hdl/gtg_pkg.sv @@
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Widths, register indexes, CORDIC angle table and gain helper.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    // datapath widths
    localparam int POS_W  = 16;          // Q10 positions
    localparam int DIF_W  = POS_W + 1;   // error vector component
    localparam int HDG_W  = 15;          // Q12 heading
    localparam int GAIN_W = 16;          // Q0.16 gains
    localparam int VW     = 60;          // vectoring lane, error scaled by 2^40
    localparam int RW     = 32;          // rotation lane, error scaled by 2^12
    localparam int ZW     = 36;          // Q30 angles
    localparam int VSHIFT = 40;
    localparam int RSHIFT = 12;
    localparam int HSHIFT = 18;          // Q12 -> Q30

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN          = 3'd4;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;

    // per-item sideband that follows the CORDIC lanes
    typedef struct packed {
        logic                   zero;   // target reached, angle forced to 0
        logic signed [ZW-1:0]   hq;     // heading in Q30
    } t_side;

    // atan(2^-i) in Q30, rounded
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 36'sd843314857;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043837;
            3:       v = 36'sd133525159;
            4:       v = 36'sd67021687;
            5:       v = 36'sd33543516;
            6:       v = 36'sd16775851;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194283;
            9:       v = 36'sd2097149;
            10:      v = 36'sd1048576;
            11:      v = 36'sd524288;
            default: v = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
        endcase
        return v;
    endfunction

    // CORDIC magnitude of (2^30, 0) after the given number of iterations
    function automatic longint cordic_gain(input int stages);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = longint'(1) <<< 30;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_MAX; i++) begin
            if (i < stages) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                end else begin
                    x = x - ys;
                    y = y + xs;
                end
            end
        end
        return x;
    endfunction

endpackage

@@ hdl/gtg_cordic.sv @@
// ----------------------------------------------------------------------------
// gtg_cordic: dual-lane pipelined CORDIC
// Vectoring lane gives the error-vector angle, rotation lane the projection
// onto the heading. One iteration per register stage, shared stall enable.
// ----------------------------------------------------------------------------
module gtg_cordic #(
    parameter int STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  gtg_pkg::t_side                i_side,
    input  logic signed [gtg_pkg::VW-1:0] i_vx,
    input  logic signed [gtg_pkg::VW-1:0] i_vy,
    input  logic signed [gtg_pkg::ZW-1:0] i_vz,
    input  logic signed [gtg_pkg::RW-1:0] i_rx,
    input  logic signed [gtg_pkg::RW-1:0] i_ry,
    input  logic signed [gtg_pkg::ZW-1:0] i_rz,
    output logic                          o_valid,
    output gtg_pkg::t_side                o_side,
    output logic signed [gtg_pkg::ZW-1:0] o_vz,
    output logic signed [gtg_pkg::RW-1:0] o_rx
);
    import gtg_pkg::*;

    logic                 r_vld [0:STAGES];
    t_side                r_sd  [0:STAGES];
    logic signed [VW-1:0] r_vx  [0:STAGES];
    logic signed [VW-1:0] r_vy  [0:STAGES];
    logic signed [ZW-1:0] r_vz  [0:STAGES];
    logic signed [RW-1:0] r_rx  [0:STAGES];
    logic signed [RW-1:0] r_ry  [0:STAGES];
    logic signed [ZW-1:0] r_rz  [0:STAGES];

    assign r_vld[0] = i_valid;
    assign r_sd[0]  = i_side;
    assign r_vx[0]  = i_vx;
    assign r_vy[0]  = i_vy;
    assign r_vz[0]  = i_vz;
    assign r_rx[0]  = i_rx;
    assign r_ry[0]  = i_ry;
    assign r_rz[0]  = i_rz;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
        logic signed [VW-1:0] vxs;
        logic signed [VW-1:0] vys;
        logic signed [RW-1:0] rxs;
        logic signed [RW-1:0] rys;

        assign vxs = r_vx[i] >>> i;
        assign vys = r_vy[i] >>> i;
        assign rxs = r_rx[i] >>> i;
        assign rys = r_ry[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[i+1] <= r_sd[i];
                // drive y toward zero
                if (!r_vy[i][VW-1]) begin
                    r_vx[i+1] <= r_vx[i] + vys;
                    r_vy[i+1] <= r_vy[i] - vxs;
                    r_vz[i+1] <= r_vz[i] + ATAN;
                end else begin
                    r_vx[i+1] <= r_vx[i] - vys;
                    r_vy[i+1] <= r_vy[i] + vxs;
                    r_vz[i+1] <= r_vz[i] - ATAN;
                end
                // drive z toward zero
                if (!r_rz[i][ZW-1]) begin
                    r_rx[i+1] <= r_rx[i] - rys;
                    r_ry[i+1] <= r_ry[i] + rxs;
                    r_rz[i+1] <= r_rz[i] - ATAN;
                end else begin
                    r_rx[i+1] <= r_rx[i] + rys;
                    r_ry[i+1] <= r_ry[i] - rxs;
                    r_rz[i+1] <= r_rz[i] + ATAN;
                end
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_side  = r_sd[STAGES];
    assign o_vz    = r_vz[STAGES];
    assign o_rx    = r_rx[STAGES];

endmodule

@@ hdl/go_to_goal_proportional_controller.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_proportional_controller: unicycle go-to-goal P controller
// Pose in, forward speed and turn rate toward the configured target out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pose per transaction (x, y in Q10, heading in Q12).
//   m_axis returns one command per pose (linear speed Q10, turn rate Q12)
//   while the run register is set; poses taken while run is clear give none.
//   Configuration: write target, gains and run through i_cfg_* while idle.
//   A pose passes stage 0, the CORDIC stages, stages 1 to 5 and the output
//   register. One pose is accepted every cycle while m_axis is not stalled;
//   the rate is set by the fully pipelined CORDIC, one iteration per stage,
//   and the pipelined reciprocal divide that removes the CORDIC gain.
//   Reset clears all stage valid bits and loads the register defaults
//   (target 0,0, gains 0.2 and 0.5, run clear).
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module go_to_goal_proportional_controller #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cur_x[15:0], cur_y[31:16], cur_heading[46:32], zero fill
    input  logic [47:0]                       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // linear_speed[15:0], turn_rate[31:16]
    output logic [31:0]                       m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_wr_en,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gtg_pkg::GAIN_W-1:0]        i_cfg_wdata
);
    import gtg_pkg::*;

    localparam longint GAIN_L  = cordic_gain(CORDIC_STAGES);
    localparam longint RECIP_L = (longint'(1) <<< 61) / GAIN_L;
    localparam logic [30:0] GAIN_Q = 31'(GAIN_L);
    localparam logic [31:0] RECIP  = 32'(RECIP_L);
    localparam int TPW = ZW + GAIN_W + 1;
    localparam logic signed [TPW-1:0] TURN_HALF = TPW'(1) <<< 33;
    localparam logic [48:0] LIN_HALF = 49'(1) << 27;

    // configuration
    logic signed [POS_W-1:0] r_tgt_x;
    logic signed [POS_W-1:0] r_tgt_y;
    logic [GAIN_W-1:0]       r_lin_gain;
    logic [GAIN_W-1:0]       r_ang_gain;
    logic                    r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x    <= '0;
            r_tgt_y    <= '0;
            r_lin_gain <= 16'd13107;
            r_ang_gain <= 16'd32768;
            r_run      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_TARGET_X:     r_tgt_x    <= i_cfg_wdata;
                REG_TARGET_Y:     r_tgt_y    <= i_cfg_wdata;
                REG_LINEAR_GAIN:  r_lin_gain <= i_cfg_wdata;
                REG_ANGULAR_GAIN: r_ang_gain <= i_cfg_wdata;
                REG_RUN:          r_run      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 0: error vector ----
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [HDG_W-1:0] cur_hdg;
    logic signed [DIF_W-1:0] n_dx;
    logic signed [DIF_W-1:0] n_dy;

    assign cur_x   = s_axis_tdata[15:0];
    assign cur_y   = s_axis_tdata[31:16];
    assign cur_hdg = s_axis_tdata[46:32];
    assign n_dx    = DIF_W'(r_tgt_x) - DIF_W'(cur_x);
    assign n_dy    = DIF_W'(r_tgt_y) - DIF_W'(cur_y);

    logic                    r_s0_vld;
    logic signed [DIF_W-1:0] r_s0_dx;
    logic signed [DIF_W-1:0] r_s0_dy;
    logic signed [ZW-1:0]    r_s0_hq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= s_axis_tvalid && r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_dx <= n_dx;
            r_s0_dy <= n_dy;
            r_s0_hq <= ZW'(cur_hdg) <<< HSHIFT;
        end
    end

    // quadrant pre-rotation for both lanes
    logic signed [VW-1:0] vx0;
    logic signed [VW-1:0] vy0;
    logic signed [ZW-1:0] vz0;
    logic signed [RW-1:0] rx0;
    logic signed [RW-1:0] ry0;
    logic signed [ZW-1:0] rz0;
    logic signed [VW-1:0] vx_raw;
    logic signed [VW-1:0] vy_raw;
    logic signed [RW-1:0] rx_raw;
    logic signed [RW-1:0] ry_raw;
    logic signed [ZW-1:0] rz_raw;
    t_side                side0;

    always_comb begin
        vx_raw = VW'(r_s0_dx) <<< VSHIFT;
        vy_raw = VW'(r_s0_dy) <<< VSHIFT;
        rx_raw = RW'(r_s0_dx) <<< RSHIFT;
        ry_raw = RW'(r_s0_dy) <<< RSHIFT;
        rz_raw = -r_s0_hq;
        if (r_s0_dx[DIF_W-1]) begin
            vx0 = -vx_raw;
            vy0 = -vy_raw;
            vz0 = r_s0_dy[DIF_W-1] ? -PI_Q30 : PI_Q30;
        end else begin
            vx0 = vx_raw;
            vy0 = vy_raw;
            vz0 = '0;
        end
        if (rz_raw > HALF_PI_Q30) begin
            rx0 = -rx_raw;
            ry0 = -ry_raw;
            rz0 = rz_raw - PI_Q30;
        end else if (rz_raw < -HALF_PI_Q30) begin
            rx0 = -rx_raw;
            ry0 = -ry_raw;
            rz0 = rz_raw + PI_Q30;
        end else begin
            rx0 = rx_raw;
            ry0 = ry_raw;
            rz0 = rz_raw;
        end
        side0.zero = (r_s0_dx == '0) && (r_s0_dy == '0);
        side0.hq   = r_s0_hq;
    end

    logic                 c_vld;
    t_side                c_side;
    logic signed [ZW-1:0] c_vz;
    logic signed [RW-1:0] c_rx;

    gtg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_vld),
        .i_side  (side0),
        .i_vx    (vx0),
        .i_vy    (vy0),
        .i_vz    (vz0),
        .i_rx    (rx0),
        .i_ry    (ry0),
        .i_rz    (rz0),
        .o_valid (c_vld),
        .o_side  (c_side),
        .o_vz    (c_vz),
        .o_rx    (c_rx)
    );

    // ---- stage 1: heading error, projection sign ----
    logic                 r_s1_vld;
    logic signed [ZW-1:0] r_s1_err;
    logic [RW-2:0]        r_s1_xr;
    logic                 r_s1_pos;
    logic                 r_s1_zero;

    // ---- stage 2: gain products ----
    logic                  r_s2_vld;
    logic [62:0]           r_s2_pq;
    logic signed [TPW-1:0] r_s2_tp;
    logic [RW-2:0]         r_s2_xr;
    logic                  r_s2_pos;
    logic                  r_s2_zero;

    // ---- stage 3: quotient estimate times gain ----
    logic                 r_s3_vld;
    logic [31:0]          r_s3_q0;
    logic [61:0]          r_s3_qg;
    logic [60:0]          r_s3_num;
    logic signed [15:0]   r_s3_turn;
    logic                 r_s3_pos;
    logic                 r_s3_zero;

    // ---- stage 4: quotient correction ----
    logic                 r_s4_vld;
    logic [32:0]          r_s4_proj;
    logic signed [15:0]   r_s4_turn;
    logic                 r_s4_pos;
    logic                 r_s4_zero;

    // ---- stage 5: linear gain ----
    logic                 r_s5_vld;
    logic [48:0]          r_s5_lp;
    logic signed [15:0]   r_s5_turn;
    logic                 r_s5_pos;
    logic                 r_s5_zero;

    // ---- output register ----
    logic                 r_out_vld;
    logic [15:0]          r_out_lin;
    logic signed [15:0]   r_out_turn;
    logic                 r_out_zero;

    logic [31:0]           q0;
    logic signed [TPW-1:0] turn_sum;
    logic signed [TPW-1:0] turn_sh;
    logic signed [15:0]    turn_sat;
    logic [61:0]           rem;
    logic [48:0]           lin_sum;
    logic [20:0]           lin_sh;
    logic [15:0]           lin_sat;

    assign q0       = r_s2_pq[62:31];
    assign turn_sum = r_s2_tp + TURN_HALF;
    assign turn_sh  = turn_sum >>> 34;
    assign rem      = {1'b0, r_s3_num} - r_s3_qg;
    assign lin_sum  = r_s5_lp + LIN_HALF;
    assign lin_sh   = lin_sum[48:28];

    always_comb begin
        if (turn_sh > TPW'(32767)) begin
            turn_sat = 16'sh7FFF;
        end else if (turn_sh < -TPW'(32768)) begin
            turn_sat = -16'sh8000;
        end else begin
            turn_sat = turn_sh[15:0];
        end
        if (!r_s5_pos) begin
            lin_sat = '0;
        end else if (lin_sh > 21'd65535) begin
            lin_sat = 16'hFFFF;
        end else begin
            lin_sat = lin_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= c_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_out_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_err  <= (c_side.zero ? '0 : c_vz) - c_side.hq;
            r_s1_pos  <= !c_rx[RW-1] && (c_rx != '0);
            r_s1_xr   <= c_rx[RW-2:0];
            r_s1_zero <= c_side.zero;

            r_s2_pq   <= 63'(r_s1_xr) * 63'(RECIP);
            r_s2_tp   <= TPW'(r_s1_err) * TPW'($signed({1'b0, r_ang_gain}));
            r_s2_xr   <= r_s1_xr;
            r_s2_pos  <= r_s1_pos;
            r_s2_zero <= r_s1_zero;

            r_s3_q0   <= q0;
            r_s3_qg   <= 62'(q0) * 62'(GAIN_Q);
            r_s3_num  <= {r_s2_xr, 30'd0};
            r_s3_turn <= turn_sat;
            r_s3_pos  <= r_s2_pos;
            r_s3_zero <= r_s2_zero;

            // estimate is low by at most one
            r_s4_proj <= {1'b0, r_s3_q0} + 33'(rem >= 62'(GAIN_Q));
            r_s4_turn <= r_s3_turn;
            r_s4_pos  <= r_s3_pos;
            r_s4_zero <= r_s3_zero;

            r_s5_lp   <= 49'(r_s4_proj) * 49'(r_lin_gain);
            r_s5_turn <= r_s4_turn;
            r_s5_pos  <= r_s4_pos;
            r_s5_zero <= r_s4_zero;

            r_out_lin  <= lin_sat;
            r_out_turn <= r_s5_turn;
            r_out_zero <= r_s5_zero;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_turn, r_out_lin};

    // assertions
    a_div_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld && r_s3_pos |-> !rem[61] && (rem < (62'(GAIN_Q) << 1)))
        else $error("projection quotient estimate out of correction range");

    a_goal_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_zero |-> r_out_lin == '0)
        else $error("nonzero speed at target");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !r_s0_vld)
        else $error("valid after reset");

endmodule

@@ tb/sv/go_to_goal_proportional_controller_test.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_proportional_controller_test: self-checking regression
// Drives poses over the input stream, predicts each speed and turn command
// with a bit-level CORDIC predictor and checks the output stream against it,
// within 2 LSB per field, across several target and gain settings.
// ----------------------------------------------------------------------------
module go_to_goal_proportional_controller_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gtg_pkg::*;

    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int LATENCY   = STAGES + 7;
    localparam int TOL       = 2;
    localparam int WD_LIMIT  = 20000;
    localparam int PRESS_LEN = 300;

    typedef struct {
        logic [15:0]        lin;
        logic signed [15:0] turn;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GAIN_W-1:0]    i_cfg_wdata = '0;

    go_to_goal_proportional_controller #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic signed [15:0] goal_x = '0;
    logic signed [15:0] goal_y = '0;
    logic [15:0]        lin_gain = 16'd13107;
    logic [15:0]        ang_gain = 16'd32768;
    logic               run_on = 1'b0;

    longint atan_lut[STAGES];
    longint pi_fx, half_pi_fx, cordic_k;

    t_cmd cmd_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    int   press_req = 0;
    int   press_seen = 0;
    int   hold = 0;

    function automatic longint atan_recip(longint unsigned n);
        longint unsigned p;
        longint sum;
        longint unsigned k;
        longint term;
        p = (64'd1 << 62) / n;
        sum = 0;
        k = 0;
        while (p != 0) begin
            term = longint'(p / (2 * k + 1));
            sum = (k[0]) ? sum - term : sum + term;
            p = p / (n * n);
            k++;
        end
        return sum;
    endfunction

    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint z;
        longint xs, ys;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? pi_fx : -pi_fx;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_lut[i];
            end else begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint rotate_proj(longint x, longint y, longint z);
        longint xs, ys;
        if (z > half_pi_fx) begin
            x = -x; y = -y; z -= pi_fx;
        end else if (z < -half_pi_fx) begin
            x = -x; y = -y; z += pi_fx;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_lut[i];
            end else begin
                x += ys; y -= xs; z += atan_lut[i];
            end
        end
        return x;
    endfunction

    function automatic void build_luts();
        longint a1, unused;
        a1 = atan_recip(2) + atan_recip(3);
        atan_lut[0] = (a1 + (64'sd1 << 31)) >>> 32;
        for (int i = 1; i < STAGES; i++)
            atan_lut[i] = (atan_recip(64'd1 << i) + (64'sd1 << 31)) >>> 32;
        pi_fx = (a1 + (64'sd1 << 29)) >>> 30;
        half_pi_fx = (a1 + (64'sd1 << 30)) >>> 31;
        unused = vector_angle(64'sd1 << 30, 0, cordic_k);
        if (cordic_k <= 0) cordic_k = 64'sd1 << 30;
    endfunction

    function automatic t_cmd steer_command(logic [47:0] pose);
        t_cmd c;
        longint dx, dy, hq, ang, err, turn, xr, proj, mag;
        longint unsigned lin;
        dx = longint'(goal_x) - longint'($signed(pose[15:0]));
        dy = longint'(goal_y) - longint'($signed(pose[31:16]));
        hq = longint'($signed(pose[46:32])) * (64'sd1 << HSHIFT);
        ang = (dx == 0 && dy == 0) ? 0 :
              vector_angle(dx * (64'sd1 << VSHIFT), dy * (64'sd1 << VSHIFT), mag);
        err = ang - hq;
        turn = (err * longint'({1'b0, ang_gain}) + (64'sd1 << 33)) >>> 34;
        if (turn > 32767) turn = 32767;
        if (turn < -32768) turn = -32768;
        xr = rotate_proj(dx * 4096, dy * 4096, -hq);
        proj = (xr * (64'sd1 << 30)) / cordic_k;
        if (proj <= 0) lin = 0;
        else begin
            lin = (longint'(proj) * longint'({1'b0, lin_gain}) + (64'sd1 << 27)) >> 28;
            if (lin > 65535) lin = 65535;
        end
        c.lin = lin[15:0];
        c.turn = turn[15:0];
        return c;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // scoreboard: output check first, then predict from the accepted pose
    always @(posedge i_clk) begin
        t_cmd exp_c;
        int dl, dt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cmd_q.size() == 0)
                report_mismatch($sformatf("unexpected command %h", m_axis_tdata));
            else begin
                exp_c = cmd_q.pop_front();
                dl = int'(m_axis_tdata[15:0]) - int'(exp_c.lin);
                dt = int'($signed(m_axis_tdata[31:16])) - int'(exp_c.turn);
                if (dl > TOL || dl < -TOL)
                    report_mismatch($sformatf("linear_speed %0d expected %0d",
                                              m_axis_tdata[15:0], exp_c.lin));
                if (dt > TOL || dt < -TOL)
                    report_mismatch($sformatf("turn_rate %0d expected %0d",
                                              $signed(m_axis_tdata[31:16]), exp_c.turn));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready && run_on)
            cmd_q.push_back(steer_command(s_axis_tdata));
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (press_req != press_seen) begin
            press_seen <= press_req;
            hold <= PRESS_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold > 0) begin
            hold <= hold - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                hold <= $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (r >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_TARGET_X:     goal_x = val;
            REG_TARGET_Y:     goal_y = val;
            REG_LINEAR_GAIN:  lin_gain = val;
            REG_ANGULAR_GAIN: ang_gain = val;
            REG_RUN:          run_on = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] tx, logic [15:0] ty, logic [15:0] lg,
                              logic [15:0] ag, bit rn);
        cfg_write(REG_TARGET_X, tx);
        cfg_write(REG_TARGET_Y, ty);
        cfg_write(REG_LINEAR_GAIN, lg);
        cfg_write(REG_ANGULAR_GAIN, ag);
        cfg_write(REG_RUN, {15'd0, rn});
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high across back-to-back transactions
    task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [14:0] h);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = quiet ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, h, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [14:0] rand_heading();
        if ($urandom_range(0, 9) == 0) return 15'($urandom);
        return 15'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    task automatic random_poses(int n);
        logic [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                // close to the goal
                x = goal_x + 16'($signed($urandom_range(0, 64)) - 32);
                y = goal_y + 16'($signed($urandom_range(0, 64)) - 32);
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_pose(x, y, rand_heading());
        end
    endtask

    task automatic test_run_clear();
        for (int i = 0; i < 8; i++) send_pose(16'($urandom), 16'($urandom), rand_heading());
        drain();
    endtask

    task automatic test_directed();
        set_config(16'd0, 16'd0, 16'd13107, 16'd32768, 1'b1);
        send_pose(16'd0, 16'd0, 15'd0);                    // at the goal
        send_pose(16'd0, 16'd0, 15'd12868);
        send_pose(16'h8000, 16'h8000, 15'd0);
        send_pose(16'h7fff, 16'h7fff, -15'sd12868);
        send_pose(16'h8000, 16'h7fff, 15'd12868);
        send_pose(16'h7fff, 16'h8000, 15'h4000);           // heading beyond pi
        send_pose(16'd1024, 16'd0, 15'h3fff);
        send_pose(16'hfc00, 16'd0, 15'd0);                 // goal ahead
        send_pose(16'd0, 16'd1, 15'd0);
        drain();
        set_config(16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1'b1);
        send_pose(16'h8000, 16'h8000, 15'd3217);           // saturating speed
        send_pose(16'h8000, 16'h7fff, -15'sd12868);
        send_pose(16'h7fff, 16'h7fff, 15'd0);
        send_pose(16'h7fff, 16'h8000, 15'h4000);
        drain();
        set_config(16'h8000, 16'h8000, 16'd0, 16'd0, 1'b1);
        send_pose(16'h7fff, 16'h7fff, 15'd100);
        send_pose(16'h8000, 16'h8000, 15'd0);
        send_pose(16'd0, 16'h8000, 15'h4000);
        drain();
    endtask

    task automatic test_unknown_index();
        for (int i = 5; i < 8; i++) cfg_write(CFG_IDX_W'(i), 16'($urandom));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        random_poses(10);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 2);
            case (ph)
                0: set_config(16'd0, 16'd0, 16'd13107, 16'd32768, 1'b1);
                1: set_config(16'h7fff, 16'h8000, 16'hffff, 16'd0, 1'b1);
                3: set_config(16'h8000, 16'h7fff, 16'd0, 16'hffff, 1'b1);
                5: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 1'b0);
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 1'b1);
            endcase
            if (ph == 4) press_req++;
            random_poses(ph == 5 ? 40 : 200);
            drain();
        end
        quiet = 1'b0;
    endtask

    initial begin
        build_luts();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_run_clear();
        test_directed();
        test_unknown_index();
        test_random_settings();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
